// ===== sv/cia_pkg.sv =====
// Shared types and constants for the checked 64-bit integer ALU.
package cia_pkg;

    localparam int WORD_W    = 64;
    localparam int DIV_STEPS = 64;
    localparam int HALF_W    = 32;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_REM  = 5'd4;
    localparam logic [4:0] OP_SHL  = 5'd5;
    localparam logic [4:0] OP_SHR  = 5'd6;
    localparam logic [4:0] OP_AND  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_EQ   = 5'd10;
    localparam logic [4:0] OP_NE   = 5'd11;
    localparam logic [4:0] OP_LT   = 5'd12;
    localparam logic [4:0] OP_GT   = 5'd13;
    localparam logic [4:0] OP_LE   = 5'd14;
    localparam logic [4:0] OP_GE   = 5'd15;
    localparam logic [4:0] OP_LAND = 5'd16;
    localparam logic [4:0] OP_LOR  = 5'd17;
    localparam logic [4:0] OP_PLUS = 5'd18;
    localparam logic [4:0] OP_NEG  = 5'd19;
    localparam logic [4:0] OP_NOT  = 5'd20;

    localparam logic [1:0] SEL_SIMPLE = 2'd0;
    localparam logic [1:0] SEL_MUL    = 2'd1;
    localparam logic [1:0] SEL_DIV    = 2'd2;
    localparam logic [1:0] SEL_REM    = 2'd3;

    localparam logic [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    // Sideband that travels next to the divider stages.
    typedef struct packed {
        logic [1:0]        sel;
        logic [WORD_W-1:0] val;
        logic              isb;
        logic              err;
        logic              negq;
        logic              negr;
    } t_side;

endpackage

// ===== sv/checked_int64_alu.sv =====
// Throughput: one item per cycle while the output register is empty or taken;
// every unit, the 64-stage divider included, is fully pipelined.
// An item passes 66 register stages: decode, 64 divider stages and the output register.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (synchronous, active low) clears only the stage valid bits; data registers keep
// whatever they held and are ignored until a valid item reaches them.
module checked_int64_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [4:0]                 i_action,
    input  logic [cia_pkg::WORD_W-1:0] i_lhs_value,
    input  logic [cia_pkg::WORD_W-1:0] i_rhs_value,
    input  logic                       i_lhs_is_bool,
    input  logic                       i_rhs_is_bool,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cia_pkg::WORD_W-1:0] o_result_value,
    output logic                       o_result_is_bool,
    output logic                       o_error
);
    import cia_pkg::*;

    // One enable moves every stage: nothing is dropped or duplicated on a stall,
    // and bubbles just travel as invalid slots.
    logic              en;
    logic              r_vld [DIV_STEPS+1];
    t_side             r_side [1:DIV_STEPS];
    t_side             side0;
    t_side             n_side2;
    logic [WORD_W-1:0] a0, b0, ma0, mb0, prod, quot, remd;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_val;
    logic              r_out_isb, r_out_err;
    logic [WORD_W-1:0] n_out_val;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    cia_front u_front (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_action (i_action),
        .i_a      (i_lhs_value),
        .i_b      (i_rhs_value),
        .i_a_bool (i_lhs_is_bool),
        .i_b_bool (i_rhs_is_bool),
        .o_side   (side0),
        .o_a      (a0),
        .o_b      (b0),
        .o_ma     (ma0),
        .o_mb     (mb0)
    );

    // The multiplier registers its partial products in stage 1; the sum is taken
    // into the sideband value at stage 2.
    cia_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (a0),
        .i_b    (b0),
        .o_prod (prod)
    );

    cia_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ma   (ma0),
        .i_mb   (mb0),
        .o_quot (quot),
        .o_rem  (remd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DIV_STEPS; k++) r_vld[k] <= r_vld[k-1];
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    // A multiply picks up its product on the way into stage 2.
    always_comb begin
        n_side2 = r_side[1];
        if (r_side[1].sel == SEL_MUL) n_side2.val = prod;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= side0;
            r_side[2] <= n_side2;
            for (int k = 3; k <= DIV_STEPS; k++) r_side[k] <= r_side[k-1];
        end
    end

    // Signs are restored on the unsigned quotient and remainder at the output.
    always_comb begin
        case (r_side[DIV_STEPS].sel)
            SEL_DIV: n_out_val = r_side[DIV_STEPS].negq ? ('0 - quot) : quot;
            SEL_REM: n_out_val = r_side[DIV_STEPS].negr ? ('0 - remd) : remd;
            default: n_out_val = r_side[DIV_STEPS].val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= r_side[DIV_STEPS].err ? '0 : n_out_val;
            r_out_isb <= r_side[DIV_STEPS].isb && !r_side[DIV_STEPS].err;
            r_out_err <= r_side[DIV_STEPS].err;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result_value   = r_out_val;
    assign o_result_is_bool = r_out_isb;
    assign o_error          = r_out_err;

    a_err_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_result_value == '0 && !o_result_is_bool))
        else $error("trapped result carries a value");

    a_bool_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_is_bool) |-> (o_result_value[WORD_W-1:1] == '0))
        else $error("boolean result is not 0 or 1");

    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_vld[DIV_STEPS] == $past(r_vld[DIV_STEPS])))
        else $error("pipeline moved during a stall");

endmodule

// ===== sv/cia_front.sv =====
// Decode, kind checks and simple operations of the ALU, with the first register stage.
module cia_front (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [4:0]                 i_action,
    input  logic [cia_pkg::WORD_W-1:0] i_a,
    input  logic [cia_pkg::WORD_W-1:0] i_b,
    input  logic                       i_a_bool,
    input  logic                       i_b_bool,
    output cia_pkg::t_side             o_side,
    output logic [cia_pkg::WORD_W-1:0] o_a,
    output logic [cia_pkg::WORD_W-1:0] o_b,
    output logic [cia_pkg::WORD_W-1:0] o_ma,
    output logic [cia_pkg::WORD_W-1:0] o_mb
);
    import cia_pkg::*;

    t_side             n_side;
    t_side             r_side;
    logic [WORD_W-1:0] r_a, r_b, r_ma, r_mb;
    logic              both_int, both_bool, a_nz, b_nz, lt, gt, cnt_bad;

    assign both_int  = !i_a_bool && !i_b_bool;
    assign both_bool = i_a_bool && i_b_bool;
    assign a_nz      = (i_a != '0);
    assign b_nz      = (i_b != '0);
    assign lt        = ($signed(i_a) < $signed(i_b));
    assign gt        = ($signed(i_b) < $signed(i_a));
    assign cnt_bad   = (i_b[WORD_W-1:6] != '0);

    always_comb begin
        n_side      = '0;
        n_side.sel  = SEL_SIMPLE;
        n_side.negq = i_a[WORD_W-1] ^ i_b[WORD_W-1];
        n_side.negr = i_a[WORD_W-1];
        if (i_action inside {[OP_ADD:OP_GE]} && !both_int) begin
            n_side.err = 1'b1;
        end else begin
            case (i_action)
                OP_ADD: n_side.val = i_a + i_b;
                OP_SUB: n_side.val = i_a - i_b;
                OP_MUL: n_side.sel = SEL_MUL;
                OP_DIV, OP_REM: begin
                    if (!b_nz || (i_a == MIN_WORD && i_b == '1)) begin
                        n_side.err = 1'b1;
                    end else begin
                        n_side.sel = (i_action == OP_DIV) ? SEL_DIV : SEL_REM;
                    end
                end
                OP_SHL: begin
                    if (cnt_bad) n_side.err = 1'b1;
                    else n_side.val = i_a << i_b[5:0];
                end
                OP_SHR: begin
                    if (cnt_bad) n_side.err = 1'b1;
                    else n_side.val = $signed(i_a) >>> i_b[5:0];
                end
                OP_AND: n_side.val = i_a & i_b;
                OP_OR:  n_side.val = i_a | i_b;
                OP_XOR: n_side.val = i_a ^ i_b;
                OP_EQ:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(i_a == i_b); end
                OP_NE:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(i_a != i_b); end
                OP_LT:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(lt); end
                OP_GT:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(gt); end
                OP_LE:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(!gt); end
                OP_GE:  begin n_side.isb = 1'b1; n_side.val = WORD_W'(!lt); end
                OP_LAND, OP_LOR: begin
                    if (!both_bool) begin
                        n_side.err = 1'b1;
                    end else begin
                        n_side.isb = 1'b1;
                        n_side.val = (i_action == OP_LAND) ? WORD_W'(a_nz && b_nz)
                                                           : WORD_W'(a_nz || b_nz);
                    end
                end
                OP_PLUS: begin
                    if (i_a_bool) n_side.err = 1'b1;
                    else n_side.val = i_a;
                end
                OP_NEG: begin
                    if (i_a_bool || i_a == MIN_WORD) n_side.err = 1'b1;
                    else n_side.val = '0 - i_a;
                end
                OP_NOT: begin
                    if (!i_a_bool) begin
                        n_side.err = 1'b1;
                    end else begin
                        n_side.isb = 1'b1;
                        n_side.val = WORD_W'(!a_nz);
                    end
                end
                default: n_side.err = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_a    <= i_a;
            r_b    <= i_b;
            r_ma   <= i_a[WORD_W-1] ? ('0 - i_a) : i_a;
            r_mb   <= i_b[WORD_W-1] ? ('0 - i_b) : i_b;
        end
    end

    assign o_side = r_side;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_ma   = r_ma;
    assign o_mb   = r_mb;

endmodule

// ===== sv/cia_mul.sv =====
// Low 64 bits of a 64 by 64 product from three registered 32 by 32 partial products.
module cia_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cia_pkg::WORD_W-1:0] i_a,
    input  logic [cia_pkg::WORD_W-1:0] i_b,
    output logic [cia_pkg::WORD_W-1:0] o_prod
);
    import cia_pkg::*;

    logic [WORD_W-1:0] r_ll;
    logic [HALF_W-1:0] r_lh, r_hl;

    // Only the low halves of the cross products reach the low word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[HALF_W-1:0] * i_b[HALF_W-1:0];
            r_lh <= HALF_W'(i_a[HALF_W-1:0] * i_b[WORD_W-1:HALF_W]);
            r_hl <= HALF_W'(i_a[WORD_W-1:HALF_W] * i_b[HALF_W-1:0]);
        end
    end

    assign o_prod = r_ll + {r_lh + r_hl, {HALF_W{1'b0}}};

endmodule

// ===== sv/cia_div.sv =====
// Unsigned restoring divider, one quotient bit per pipeline stage.
module cia_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cia_pkg::WORD_W-1:0] i_ma,
    input  logic [cia_pkg::WORD_W-1:0] i_mb,
    output logic [cia_pkg::WORD_W-1:0] o_quot,
    output logic [cia_pkg::WORD_W-1:0] o_rem
);
    import cia_pkg::*;

    logic [WORD_W-1:0] r_rem [DIV_STEPS];
    logic [WORD_W-1:0] r_dq  [DIV_STEPS];
    logic [WORD_W-1:0] r_d   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [WORD_W-1:0] rem_in, dq_in, d_in;
        logic [WORD_W:0]   trial, diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = i_ma;
            assign d_in   = i_mb;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dq_in  = r_dq[k-1];
            assign d_in   = r_d[k-1];
        end

        // Dividend bits shift out the top while quotient bits shift in below.
        assign trial = {rem_in, dq_in[WORD_W-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = !diff[WORD_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                r_dq[k]  <= {dq_in[WORD_W-2:0], ge};
                r_d[k]   <= d_in;
            end
        end
    end

    assign o_quot = r_dq[DIV_STEPS-1];
    assign o_rem  = r_rem[DIV_STEPS-1];

endmodule
